// ===== src/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// types, constants and helpers shared by the fenwick range-sum block
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int SIZE_DEF  = 1024;
  localparam int SUM_W_DEF = 48;

  localparam int FUNC_W  = 1;
  localparam int POS_W   = 10;
  localparam int VAL_W   = 32;
  localparam int RNG_W   = 11;
  localparam int SZ_W    = 11;
  localparam int RS_W    = 48;
  localparam int CAP_W   = 17;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [SZ_W-1:0] SIZE_IN_USE_RST = 11'd1024;

  // register index is paddr[2]
  localparam logic [0:0] REG_SIZE_IN_USE = 1'b0;

  localparam logic [FUNC_W-1:0] FUNC_ADD   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] add_value;
    logic [RNG_W-1:0]        range_low;
    logic [RNG_W-1:0]        range_high;
  } fpa_in_t;

  typedef struct packed {
    logic                   status;
    logic signed [RS_W-1:0] range_sum;
  } fpa_out_t;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic upd_rd;
    logic upd_wr;
    logic q_rd;
    logic q_neg;
    logic lo_start;
    logic out_load;
  } fpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic func_query;
    logic pos_bad;
    logic idx_zero;
    logic upd_end;
  } fpa_sts_t;

  // smallest power of two not below s (at least 1), capped at cap
  function automatic logic [CAP_W-1:0] fpa_round_len(input logic [SZ_W-1:0] s,
                                                     input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] len;
    logic [SZ_W-1:0]  m;
    len = CAP_W'(1);
    m   = (s == '0) ? '0 : s - SZ_W'(1);
    for (int b = 0; b < SZ_W; b++) begin
      if (m[b]) begin
        len = CAP_W'(1) << (b + 1);
      end
    end
    if (len > cap) begin
      len = cap;
    end
    return len;
  endfunction

endpackage

// ===== src/fpa_cfg.sv =====
// ----------------------------------------------------------------------------
// fpa_cfg
// apb register block: size_in_use and the derived used length
// ----------------------------------------------------------------------------
module fpa_cfg #(
  parameter int SIZE  = 1024,
  parameter int LEN_W = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpa_pkg::PADDR_W-1:0] paddr,
  input  logic [fpa_pkg::PDATA_W-1:0] pwdata,
  output logic [fpa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [LEN_W-1:0]            len
);
  import fpa_pkg::*;

  logic [SZ_W-1:0]  size_r;
  logic [SZ_W-1:0]  size_nxt;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic [CAP_W-1:0] len_full;
  logic [CAP_W-1:0] len_rst;
  logic             wr_en;

  assign wr_en    = psel && penable && pwrite && (paddr[2] == REG_SIZE_IN_USE);
  assign size_nxt = wr_en ? pwdata[SZ_W-1:0] : size_r;
  assign len_full = fpa_round_len(size_nxt, CAP_W'(SIZE));
  assign len_rst  = fpa_round_len(SIZE_IN_USE_RST, CAP_W'(SIZE));
  assign len_nxt  = len_full[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_IN_USE_RST;
      len_r  <= len_rst[LEN_W-1:0];
    end else begin
      size_r <= size_nxt;
      len_r  <= len_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? PDATA_W'(size_r) : '0;
  assign len    = len_r;

endmodule

// ===== src/fpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpa_ctrl
// sequencer: clearing pass, update walk, two-phase prefix query, result hand-off
// ----------------------------------------------------------------------------
module fpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fpa_pkg::fpa_sts_t sts,
  output fpa_pkg::fpa_cmd_t cmd
);
  import fpa_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DISP   = 3'd2;
  localparam logic [2:0] S_UPD_RD = 3'd3;
  localparam logic [2:0] S_UPD_WR = 3'd4;
  localparam logic [2:0] S_QHI    = 3'd5;
  localparam logic [2:0] S_QLO    = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.func_query) begin
          state_nxt = S_QHI;
        end else if (sts.pos_bad) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        if (sts.upd_end) begin
          state_nxt = S_FIN;
        end else begin
          cmd.upd_rd = 1'b1;
          state_nxt  = S_UPD_WR;
        end
      end
      S_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = S_UPD_RD;
      end
      S_QHI: begin
        if (sts.idx_zero) begin
          cmd.lo_start = 1'b1;
          state_nxt    = S_QLO;
        end else begin
          cmd.q_rd = 1'b1;
        end
      end
      S_QLO: begin
        // last node read lands in the accumulator on this edge
        if (sts.idx_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.q_rd  = 1'b1;
          cmd.q_neg = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/fpa_dp.sv =====
// ----------------------------------------------------------------------------
// fpa_dp
// node memory, walk index, accumulator and result register
// ----------------------------------------------------------------------------
module fpa_dp #(
  parameter int SIZE      = 1024,
  parameter int SUM_WIDTH = 48,
  parameter int LEN_W     = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fpa_pkg::fpa_cmd_t cmd,
  output fpa_pkg::fpa_sts_t sts,
  input  fpa_pkg::fpa_in_t  in_data,
  input  logic [LEN_W-1:0]  len,
  output fpa_pkg::fpa_out_t out_data
);
  import fpa_pkg::*;

  localparam int AW = $clog2(SIZE);
  // walk index can overshoot the length by up to one lowest-set-bit step
  localparam int IW = (LEN_W + 1 > RNG_W + 1) ? LEN_W + 1 : RNG_W + 1;

  logic [SUM_WIDTH-1:0] node_mem [SIZE];

  logic [AW-1:0]        clr_cnt_r;
  logic                 func_r;
  logic [SUM_WIDTH-1:0] val_r;
  logic [RNG_W-1:0]     lo_r;
  logic                 bad_r;
  logic [IW-1:0]        idx_r;
  logic [IW-1:0]        idx_nxt;
  logic [SUM_WIDTH-1:0] acc_r;
  logic [SUM_WIDTH-1:0] rdata_r;
  logic                 pend_r;
  logic                 pend_neg_r;
  fpa_out_t             out_data_r;

  logic [IW-1:0]        len_x;
  logic [IW-1:0]        hi_x;
  logic [IW-1:0]        lo_x;
  logic [IW-1:0]        pos_x;
  logic [IW-1:0]        low_bit;
  logic [AW-1:0]        node_addr;
  logic [IW-1:0]        idx_m1;

  assign len_x   = IW'(len);
  assign hi_x    = IW'(in_data.range_high);
  assign lo_x    = IW'(lo_r);
  assign pos_x   = IW'(in_data.position);
  assign low_bit = idx_r & (~idx_r + IW'(1));
  assign idx_m1  = idx_r - IW'(1);
  assign node_addr = idx_m1[AW-1:0];

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      if (in_data.func == FUNC_QUERY) begin
        idx_nxt = (hi_x > len_x) ? len_x : hi_x;
      end else begin
        idx_nxt = pos_x + IW'(1);
      end
    end else if (cmd.lo_start) begin
      idx_nxt = (lo_x > len_x) ? len_x : lo_x;
    end else if (cmd.upd_wr) begin
      idx_nxt = idx_r + low_bit;
    end else if (cmd.q_rd) begin
      idx_nxt = idx_r - low_bit;
    end
  end

  // node memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      node_mem[clr_cnt_r] <= '0;
    end else if (cmd.upd_wr) begin
      node_mem[node_addr] <= rdata_r + val_r;
    end
    if (cmd.upd_rd || cmd.q_rd) begin
      rdata_r <= node_mem[node_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      pend_r     <= 1'b0;
      pend_neg_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      pend_r     <= cmd.q_rd;
      pend_neg_r <= cmd.q_neg;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      func_r <= (in_data.func == FUNC_QUERY);
      val_r  <= SUM_WIDTH'($signed(in_data.add_value));
      lo_r   <= in_data.range_low;
      bad_r  <= (in_data.func == FUNC_ADD) && (pos_x >= len_x);
      acc_r  <= '0;
    end else if (pend_r) begin
      acc_r <= pend_neg_r ? acc_r - rdata_r : acc_r + rdata_r;
    end
    if (cmd.out_load) begin
      out_data_r.status    <= bad_r;
      out_data_r.range_sum <= RS_W'($signed(acc_r));
    end
  end

  assign sts.clr_last   = (clr_cnt_r == AW'(SIZE - 1));
  assign sts.func_query = func_r;
  assign sts.pos_bad    = bad_r;
  assign sts.idx_zero   = (idx_r == '0);
  assign sts.upd_end    = (idx_r > len_x);
  assign out_data       = out_data_r;

endmodule

// ===== src/fenwick_point_add_range_sum.sv =====
// one item at a time, next item taken the cycle after a result is loaded; in_ready idle-only
// update: each node on the walk up to the used length is read, then written back
//   (the node memory has one registered read port and one write port)
// query: one node read per cycle for each of two prefixes
// a result waiting on out_ready does not block the next item from being accepted
// after reset a clearing pass zeroes the node memory, in_ready low
// ----------------------------------------------------------------------------
// fenwick_point_add_range_sum
// fenwick tree with point add and range sum, apb-configured used length
// ----------------------------------------------------------------------------
module fenwick_point_add_range_sum #(
  parameter int SIZE      = fpa_pkg::SIZE_DEF,
  parameter int SUM_WIDTH = fpa_pkg::SUM_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fpa_pkg::fpa_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fpa_pkg::fpa_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpa_pkg::PADDR_W-1:0] paddr,
  input  logic [fpa_pkg::PDATA_W-1:0] pwdata,
  output logic [fpa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import fpa_pkg::*;

  localparam int LEN_W = $clog2(SIZE + 1);

  logic [LEN_W-1:0] len;
  fpa_cmd_t         cmd;
  fpa_sts_t         sts;

  fpa_cfg #(
    .SIZE  (SIZE),
    .LEN_W (LEN_W)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .len     (len)
  );

  fpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpa_dp #(
    .SIZE      (SIZE),
    .SUM_WIDTH (SUM_WIDTH),
    .LEN_W     (LEN_W)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .len      (len),
    .out_data (out_data)
  );

endmodule

// ===== src/fpa_chk.sv =====
// ----------------------------------------------------------------------------
// fpa_chk
// port-level checks for the fenwick range-sum block
// ----------------------------------------------------------------------------
module fpa_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input fpa_pkg::fpa_out_t out_data
);
  import fpa_pkg::*;

  // clearing pass keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("in_ready high during clearing pass");

  // one item in flight: an accepted item closes the input next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("result payload changed while stalled");

endmodule

bind fenwick_point_add_range_sum fpa_chk u_fpa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fenwick point-add / range-sum block: items are
// scored against an in-bench fenwick tree across several used lengths, with
// random idling on both channels and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_top;
  import fpa_pkg::*;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          HOLD_AFTER     = 250;
  localparam logic [PADDR_W-1:0] SIZE_ADDR = {REG_SIZE_IN_USE, 2'b00};

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  fpa_in_t            in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  fpa_out_t           out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // bench copy of the tree and of the size register
  logic [RS_W-1:0] node_sums [SIZE_DEF];
  logic [SZ_W-1:0] size_model = SIZE_IN_USE_RST;

  fpa_in_t  item_queue[$];
  fpa_out_t expected_results[$];

  int  fail_count    = 0;
  int  results_seen  = 0;
  int  add_count     = 0;
  int  bad_add_count = 0;
  int  query_count   = 0;
  int  size_settings = 0;
  int  stall_cycles  = 0;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;
  bit  steady        = 1'b0;

  fenwick_point_add_range_sum u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  function automatic int unsigned rounded_length(logic [SZ_W-1:0] s);
    int unsigned len;
    len = 1;
    while (len < s && len < SIZE_DEF) len <<= 1;
    return len;
  endfunction

  function automatic logic [RS_W-1:0] prefix_total(int unsigned stop, int unsigned len);
    logic [RS_W-1:0] acc;
    int unsigned     k;
    acc = '0;
    k   = (stop < len) ? stop : len;
    while (k > 0) begin
      acc += node_sums[k-1];
      k   -= k & (~k + 1);
    end
    return acc;
  endfunction

  // applies one item to the bench tree and returns the result it should give
  function automatic fpa_out_t fenwick_step(fpa_in_t it);
    fpa_out_t        res;
    int unsigned     len;
    int unsigned     k;
    logic [RS_W-1:0] delta;
    logic [RS_W-1:0] total;
    res = '0;
    len = rounded_length(size_model);
    if (it.func == FUNC_ADD) begin
      if (it.position >= len) begin
        res.status = 1'b1;
      end else begin
        delta = {{(RS_W-VAL_W){it.add_value[VAL_W-1]}}, it.add_value};
        k = it.position + 1;
        while (k <= len) begin
          node_sums[k-1] += delta;
          k += k & (~k + 1);
        end
      end
    end else begin
      total = prefix_total(it.range_high, len);
      if (it.range_low != 0) begin
        total -= prefix_total(it.range_low, len);
      end
      res.range_sum = total;
    end
    return res;
  endfunction

  function automatic fpa_in_t make_add(int unsigned pos, logic [VAL_W-1:0] value);
    fpa_in_t it;
    it            = '0;
    it.func       = FUNC_ADD;
    it.position   = POS_W'(pos);
    it.add_value  = value;
    it.range_low  = RNG_W'($urandom);
    it.range_high = RNG_W'($urandom);
    return it;
  endfunction

  function automatic fpa_in_t make_query(int unsigned lo, int unsigned hi);
    fpa_in_t it;
    it            = '0;
    it.func       = FUNC_QUERY;
    it.position   = POS_W'($urandom);
    it.add_value  = VAL_W'($urandom);
    it.range_low  = RNG_W'(lo);
    it.range_high = RNG_W'(hi);
    return it;
  endfunction

  // mostly in-range adds and ordered ranges, the rest anything the fields allow
  function automatic fpa_in_t random_item(int unsigned len);
    fpa_in_t     it;
    int unsigned pick;
    int unsigned lo;
    it.func       = $urandom_range(0, 1) ? FUNC_QUERY : FUNC_ADD;
    it.position   = POS_W'($urandom);
    it.add_value  = VAL_W'($urandom);
    it.range_low  = RNG_W'($urandom);
    it.range_high = RNG_W'($urandom);
    pick = $urandom_range(0, 99);
    if (it.func == FUNC_ADD) begin
      if (pick < 85) it.position = POS_W'($urandom_range(0, len - 1));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        it.add_value = VAL_W'(int'($urandom_range(0, 200)) - 100);
      end else if (pick < 35) begin
        it.add_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
    end else if (pick < 80) begin
      lo            = $urandom_range(0, len);
      it.range_low  = RNG_W'(lo);
      it.range_high = RNG_W'($urandom_range(lo, len));
    end
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    logic    valid_next;
    fpa_in_t data_next;
    valid_next = in_valid;
    data_next  = in_data;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(fenwick_step(in_data));
        if (in_data.func == FUNC_ADD) begin
          add_count++;
          if (in_data.position >= rounded_length(size_model)) bad_add_count++;
        end else begin
          query_count++;
        end
      end
      if (!in_valid || in_ready) begin
        valid_next = 1'b0;
        if (item_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 13)) begin
          valid_next = 1'b1;
          data_next  = item_queue.pop_front();
        end
      end
    end
    in_valid <= valid_next;
    in_data  <= data_next;
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    logic     ready_next;
    fpa_out_t want;
    ready_next = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result item: status %0d, range_sum %0d",
                 out_data.status, out_data.range_sum);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.range_sum !== want.range_sum) begin
            $error("range_sum: expected %0d, got %0d", want.range_sum, out_data.range_sum);
            fail_count++;
          end
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end else begin
        ready_next = steady || $urandom_range(0, 99) >= 13;
      end
    end
    out_ready <= ready_next;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic settle();
    while (item_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write size_in_use once the block is quiet, then read it back
  task automatic set_size(logic [SZ_W-1:0] s);
    settle();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SIZE_ADDR;
    pwdata  <= PDATA_W'(s);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    size_model = s;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[SZ_W-1:0] !== s) begin
      $error("size_in_use: expected %0d, got %0d", s, prdata[SZ_W-1:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    size_settings++;
  endtask

  task automatic queue_random(int n);
    int unsigned len;
    len = rounded_length(size_model);
    repeat (n) item_queue.push_back(random_item(len));
  endtask

  initial begin
    foreach (node_sums[j]) node_sums[j] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // full length: extreme values and positions, clamped and reversed ranges
    set_size(11'd1024);
    item_queue.push_back(make_add(0, 32'h7FFF_FFFF));
    item_queue.push_back(make_add(1023, 32'h8000_0000));
    item_queue.push_back(make_add(511, 32'hFFFF_FFFF));
    item_queue.push_back(make_add(512, 32'd12345));
    item_queue.push_back(make_query(0, 1024));
    item_queue.push_back(make_query(0, 0));
    item_queue.push_back(make_query(1024, 1024));
    item_queue.push_back(make_query(2047, 2047));
    item_queue.push_back(make_query(800, 10));
    item_queue.push_back(make_query(1, 1023));
    item_queue.push_back(make_query(0, 2047));
    item_queue.push_back(make_query(512, 513));

    // small length: adds past the end are refused
    set_size(11'd5);
    item_queue.push_back(make_add(7, 32'd100));
    item_queue.push_back(make_add(8, 32'd5));
    item_queue.push_back(make_add(1023, -32'sd7));
    item_queue.push_back(make_query(0, 2047));
    item_queue.push_back(make_query(7, 2));
    item_queue.push_back(make_query(8, 8));

    // a size of zero acts as one
    set_size(11'd0);
    item_queue.push_back(make_add(0, -32'sd50));
    item_queue.push_back(make_add(1, 32'd3));
    item_queue.push_back(make_query(0, 1));
    item_queue.push_back(make_query(1, 0));
    item_queue.push_back(make_query(0, 0));

    // largest register value is capped at the node memory
    set_size(11'd2047);
    item_queue.push_back(make_add(1023, 32'd1));
    item_queue.push_back(make_query(1000, 2047));

    set_size(11'd1024);
    queue_random(140);
    set_size(11'd5);
    queue_random(70);
    set_size(11'd1);
    queue_random(50);
    set_size(11'd0);
    queue_random(40);
    set_size(11'd2047);
    steady = 1'b1;
    queue_random(130);
    set_size(11'd300);
    steady = 1'b0;
    queue_random(100);
    set_size(11'd2);
    queue_random(50);
    set_size(11'd700);
    queue_random(70);

    settle();
    $display("covered %0d adds (%0d past the used length) and %0d queries",
             add_count, bad_add_count, query_count);
    $display("across %0d size settings, %0d results scored", size_settings, results_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fpa_pkg.sv
src/fpa_cfg.sv
src/fpa_ctrl.sv
src/fpa_dp.sv
src/fenwick_point_add_range_sum.sv
src/fpa_chk.sv
sim/tb_top.sv
